/* hdl/ps2md_pkg.sv */
// Shared types and constants for the PS/2 mouse packet decoder.
// Holds the record layout, the queue sizing and the pointer helper.
// No dependencies.
`default_nettype none

package ps2md_pkg;

    // Queue sizing: one slot stays free to tell full from empty
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Special bytes from the device
    localparam logic [7:0] BYTE_ACK     = 8'hFA;
    localparam logic [7:0] BYTE_TEST_OK = 8'hAA;

    // Header byte bit positions
    localparam int HDR_SYNC   = 3;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;
    localparam int HDR_X_OVF  = 6;
    localparam int HDR_Y_OVF  = 7;

    // Clamp values for an overflowed axis
    localparam logic signed [8:0] AXIS_MIN = -9'sd256;
    localparam logic signed [8:0] AXIS_MAX = 9'sd255;

    // Widths of the packed stream words
    localparam int IN_W  = 8;
    localparam int OUT_W = 40;

    // Decoded movement record as stored in the queue
    typedef struct packed {
        logic signed [7:0] move_wheel;
        logic signed [9:0] move_y;
        logic signed [8:0] move_x;
        logic [2:0]        buttons;
    } rec_t;

    // Control from the assembler to the queue logic
    typedef struct packed {
        logic complete;
        logic attach;
    } asm_ctl_t;

    typedef logic [PTR_W-1:0] ptr_t;

    // Advance a ring pointer, wrapping at the queue depth
    function automatic ptr_t ring_next(input ptr_t p);
        ptr_t n;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            n = '0;
        else
            n = p + PTR_W'(1);
        return n;
    endfunction

endpackage

`default_nettype wire

/* hdl/ps2md_assembler.sv */
// Packet assembler: collects mouse bytes into 3 or 4 byte packets and decodes them.
// Reports a completed record or the attach sequence to the queue logic.
// Depends on ps2md_pkg.
`default_nettype none

module ps2md_assembler
    import ps2md_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_en,
    input  wire logic [7:0] data_byte,
    input  wire logic       wheel_enabled,
    output asm_ctl_t        ctl,
    output rec_t            rec
);

    logic [1:0] count_reg, count_next;
    logic [7:0] hdr_reg, hdr_next;
    logic [7:0] xb_reg, xb_next;
    logic [7:0] yb_reg, yb_next;
    logic [7:0] y_byte;
    logic signed [8:0] ax;
    logic signed [8:0] ay;

    // Step the assembly counter and capture packet bytes
    always_comb
    begin
        count_next = count_reg;
        hdr_next   = hdr_reg;
        xb_next    = xb_reg;
        yb_next    = yb_reg;
        ctl        = '0;
        if (byte_en)
        begin
            unique case (count_reg)
                2'd0:
                begin
                    if (data_byte[HDR_SYNC] && data_byte != BYTE_ACK)
                    begin
                        hdr_next   = data_byte;
                        count_next = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (hdr_reg == BYTE_TEST_OK && data_byte == 8'h00)
                    begin
                        count_next = 2'd0;
                        ctl.attach = 1'b1;
                    end
                    else
                    begin
                        xb_next    = data_byte;
                        count_next = 2'd2;
                    end
                end
                2'd2:
                begin
                    yb_next = data_byte;
                    if (wheel_enabled)
                        count_next = 2'd3;
                    else
                    begin
                        count_next   = 2'd0;
                        ctl.complete = 1'b1;
                    end
                end
                default:
                begin
                    count_next   = 2'd0;
                    ctl.complete = 1'b1;
                end
            endcase
        end
    end

    // Hold the assembly state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Packet bytes carry no reset
    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        xb_reg  <= xb_next;
        yb_reg  <= yb_next;
    end

    // Decode the packet; the Y byte comes straight from the input on a 3 byte packet
    always_comb
    begin
        y_byte = (count_reg == 2'd2) ? data_byte : yb_reg;

        if (hdr_reg[HDR_X_OVF])
            ax = hdr_reg[HDR_X_SIGN] ? AXIS_MIN : AXIS_MAX;
        else
            ax = {hdr_reg[HDR_X_SIGN], xb_reg};

        if (hdr_reg[HDR_Y_OVF])
            ay = hdr_reg[HDR_Y_SIGN] ? AXIS_MIN : AXIS_MAX;
        else
            ay = {hdr_reg[HDR_Y_SIGN], y_byte};

        rec.buttons    = hdr_reg[2:0];
        rec.move_x     = ax;
        rec.move_y     = 10'sd0 - {ay[8], ay};
        rec.move_wheel = wheel_enabled ? data_byte : 8'h00;
    end

endmodule

`default_nettype wire

/* hdl/ps2_mouse_packet_decoder_unit.sv */
// PS/2 mouse packet decoder, top level: stream ports, record queue memory and output stages.
// Depends on ps2md_pkg and ps2md_assembler.
//
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser = 0 carries a mouse
//   byte in s_tdata[7:0]; s_tuser = 1 is a read request that pops one queued record.
//   Every input word gives exactly one result word on m_tvalid/m_tready/m_tdata.
//   The wheel register is written on cfg_valid/cfg_ready/cfg_data; the user must write it
//   only while the block is idle, which the block does not enforce. cfg_ready is always high.
// Pipeline and throughput:
//   A result passes the queue memory read register with stage A, then the output register
//   of stage B. One word per cycle is taken unless the output stalls, set by the single
//   read-modify-write of the pointers and the synchronous queue memory.
// Reset:
//   rst_n clears the assembly counter, both queue pointers, the wheel register and the valid
//   bits of both stages. The queue memory is not cleared; only written entries are read.
// Stall:
//   With m_tready low the output register holds and the stage behind it can still take one
//   more word; after that s_tready drops until the result is taken.
`default_nettype none

module ps2_mouse_packet_decoder_unit
    import ps2md_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Input stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // [7:0] data_byte
    input  wire logic             s_tuser,   // [0] kind
    // Result stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // [0] record_queued, [1] record_dropped,
                                             // [2] device_attached, [3] record_valid,
                                             // [6:4] buttons, [15:7] move_x,
                                             // [25:16] move_y, [33:26] move_wheel,
                                             // [39:34] zero
    // Configuration write
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic             cfg_data
);

    logic     wheel_reg;
    logic     s_acc;
    logic     byte_en;
    logic     rd_req;
    asm_ctl_t actl;
    rec_t     arec;

    ptr_t rp_reg, rp_next;
    ptr_t wp_reg, wp_next;
    logic empty;
    logic full;
    logic wr_en;
    logic rd_en;
    logic drop;

    rec_t mem [QUEUE_DEPTH];
    rec_t rd_data_reg;

    logic       a_valid_reg;
    logic [3:0] a_flags_reg, a_flags_next;
    logic       a_move;

    logic             b_valid_reg;
    logic [OUT_W-1:0] b_data_reg, b_data_next;

    assign cfg_ready = 1'b1;
    assign a_move    = !b_valid_reg || m_tready;
    assign s_tready  = !a_valid_reg || a_move;
    assign s_acc     = s_tvalid && s_tready;
    assign byte_en   = s_acc && !s_tuser;
    assign rd_req    = s_acc && s_tuser;

    // Hold the wheel register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wheel_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            wheel_reg <= cfg_data;
    end

    ps2md_assembler u_asm (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_en       (byte_en),
        .data_byte     (s_tdata[7:0]),
        .wheel_enabled (wheel_reg),
        .ctl           (actl),
        .rec           (arec)
    );

    // Queue control: push, pop and flush
    always_comb
    begin
        empty   = (rp_reg == wp_reg);
        full    = (ring_next(wp_reg) == rp_reg);
        wr_en   = actl.complete && !full;
        drop    = actl.complete && full;
        rd_en   = rd_req && !empty;
        rp_next = rp_reg;
        wp_next = wp_reg;
        if (actl.attach)
        begin
            rp_next = '0;
            wp_next = '0;
        end
        else
        begin
            if (wr_en)
                wp_next = ring_next(wp_reg);
            if (rd_en)
                rp_next = ring_next(rp_reg);
        end
        a_flags_next = {rd_en, actl.attach, drop, wr_en};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg <= '0;
            wp_reg <= '0;
        end
        else
        begin
            rp_reg <= rp_next;
            wp_reg <= wp_next;
        end
    end

    // Queue memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= arec;
        if (rd_en)
            rd_data_reg <= mem[rp_reg];
    end

    // Stage A: flags beside the memory read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            a_flags_reg <= 4'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= s_acc;
            a_flags_reg <= a_flags_next;
        end
    end

    // Format the result word; zero the record fields unless a record was popped
    always_comb
    begin
        b_data_next        = '0;
        b_data_next[3:0]   = a_flags_reg;
        if (a_flags_reg[3])
        begin
            b_data_next[6:4]   = rd_data_reg.buttons;
            b_data_next[15:7]  = rd_data_reg.move_x;
            b_data_next[25:16] = rd_data_reg.move_y;
            b_data_next[33:26] = rd_data_reg.move_wheel;
        end
    end

    // Stage B: output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (a_move)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (a_move && a_valid_reg)
            b_data_reg <= b_data_next;
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = b_data_reg;

endmodule

`default_nettype wire

/* verif/ps2md_checker.sv */
// Checker for the PS/2 mouse packet decoder: watches the input, config and result streams.
// Keeps its own packet assembler and record ring, predicts every result word and compares.
// Depends on ps2md_pkg for the record layout, queue depth and header bit positions.
`timescale 1ns / 100ps

module ps2md_checker
    import ps2md_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             s_tuser,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic             cfg_data,
    output int               fail_count,
    output int               outstanding
);

    // Result word as it leaves the block, lowest field last
    typedef struct packed {
        logic [5:0] pad;
        rec_t       rec;
        logic       valid;
        logic       attached;
        logic       dropped;
        logic       queued;
    } result_word_t;

    // Predicted decoder state
    logic       wheel_on;
    int         held_bytes;
    logic [7:0] head_byte;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
    rec_t       ring [QUEUE_DEPTH];
    int         rd_slot;
    int         wr_slot;

    result_word_t expected_words [$];
    int           errors = 0;

    function automatic int slot_after(input int p);
        return (p == QUEUE_DEPTH - 1) ? 0 : p + 1;
    endfunction

    // One axis: clamp on overflow, else sign-extend the ninth bit
    function automatic int axis_delta(input logic [7:0] head, input int sign_bit,
                                      input int ovf_bit, input logic [7:0] mag);
        if (head[ovf_bit])
            return head[sign_bit] ? int'(AXIS_MIN) : int'(AXIS_MAX);
        return int'(mag) - (head[sign_bit] ? 256 : 0);
    endfunction

    function automatic rec_t make_record(input logic [7:0] fourth);
        rec_t r;
        r.buttons    = head_byte[2:0];
        r.move_x     = 9'(axis_delta(head_byte, HDR_X_SIGN, HDR_X_OVF, x_byte));
        r.move_y     = 10'(-axis_delta(head_byte, HDR_Y_SIGN, HDR_Y_OVF, y_byte));
        r.move_wheel = wheel_on ? fourth : 8'h00;
        return r;
    endfunction

    // Advance the predicted state by one accepted word and return its result
    function automatic result_word_t decode_step(input logic is_read, input logic [7:0] b);
        result_word_t res;
        res = '0;
        if (is_read) begin
            if (rd_slot != wr_slot) begin
                res.valid = 1'b1;
                res.rec   = ring[rd_slot];
                rd_slot   = slot_after(rd_slot);
            end
        end
        else if (held_bytes == 0) begin
            // drop bytes out of sync and a lone acknowledge
            if (b[HDR_SYNC] && b != BYTE_ACK) begin
                head_byte  = b;
                held_bytes = 1;
            end
        end
        else if (held_bytes == 1) begin
            if (head_byte == BYTE_TEST_OK && b == 8'h00) begin
                held_bytes   = 0;
                rd_slot      = 0;
                wr_slot      = 0;
                res.attached = 1'b1;
            end
            else begin
                x_byte     = b;
                held_bytes = 2;
            end
        end
        else if (held_bytes == 2 && wheel_on) begin
            y_byte     = b;
            held_bytes = 3;
        end
        else begin
            // packet complete: third byte without wheel, or fourth byte
            if (held_bytes == 2)
                y_byte = b;
            held_bytes = 0;
            if (slot_after(wr_slot) == rd_slot)
                res.dropped = 1'b1;
            else begin
                ring[wr_slot] = make_record(b);
                wr_slot       = slot_after(wr_slot);
                res.queued    = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Track config, predict on input words, compare on result words
    always @(posedge clk or negedge rst_n) begin
        result_word_t want;
        result_word_t got;
        if (!rst_n) begin
            wheel_on   = 1'b0;
            held_bytes = 0;
            rd_slot    = 0;
            wr_slot    = 0;
            expected_words.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_valid && cfg_ready)
                wheel_on = cfg_data;
            if (s_tvalid && s_tready)
                expected_words.push_back(decode_step(s_tuser, s_tdata[7:0]));
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_words.size() == 0) begin
                    $error("result word with nothing expected: %h", m_tdata);
                    errors++;
                end
                else begin
                    want = expected_words.pop_front();
                    check_field("record_queued", want.queued, got.queued);
                    check_field("record_dropped", want.dropped, got.dropped);
                    check_field("device_attached", want.attached, got.attached);
                    check_field("record_valid", want.valid, got.valid);
                    check_field("buttons", want.rec.buttons, got.rec.buttons);
                    check_field("move_x", int'(want.rec.move_x), int'(got.rec.move_x));
                    check_field("move_y", int'(want.rec.move_y), int'(got.rec.move_y));
                    check_field("move_wheel", int'(want.rec.move_wheel),
                                int'(got.rec.move_wheel));
                    check_field("pad", want.pad, got.pad);
                end
            end
            fail_count  <= errors;
            outstanding <= expected_words.size();
        end
    end

endmodule

/* verif/tb.sv */
// Top of the PS/2 mouse packet decoder testbench: clock, reset, stimulus and verdict.
// Drives directed and random mouse bytes and read requests with random idling on both sides.
// Depends on ps2md_pkg, ps2_mouse_packet_decoder_unit and ps2md_checker.
`timescale 1ns / 100ps

module tb
    import ps2md_pkg::*;
();

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_READ = 1'b1;
    localparam int   RANDOM_WORDS = 650;
    localparam int   PHASES = 6;
    localparam int   LONG_HOLD = 80;

    logic             clk;
    logic             rst_n = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             s_tuser = 1'b0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_data = 1'b0;
    int               fail_count;
    int               outstanding;

    // Stimulus controls shared with the receiver
    logic gaps_on = 1'b1;
    logic stall_on = 1'b1;
    logic hold_request = 1'b0;
    logic wheel_now = 1'b0;
    int   words_sent = 0;
    int   read_share [PHASES] = '{8, 45, 25, 70, 15, 40};

    ps2_mouse_packet_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    ps2md_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest correct run
    initial
    begin
        #4ms;
        $display("tb: done, errors");
        $finish;
    end

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap(input logic enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: random back-pressure, or one long hold when asked
    initial
    begin
        int len;
        @(posedge clk);
        forever
        begin
            len = pick_gap(stall_on);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (len == 0) begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else begin
                m_tready <= 1'b0;
                repeat (len) @(posedge clk);
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one word, optionally after an idle gap, and hold until taken
    task automatic push_word(input logic kind, input logic [7:0] b);
        int gap;
        gap = pick_gap(gaps_on);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic send_packet(input logic [7:0] head, input logic [7:0] dx,
                               input logic [7:0] dy, input logic [7:0] dz);
        push_word(KIND_BYTE, head);
        push_word(KIND_BYTE, dx);
        push_word(KIND_BYTE, dy);
        if (wheel_now)
            push_word(KIND_BYTE, dz);
    endtask

    // Stop offering and wait until every predicted word has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_wheel(input logic on);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= on;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        wheel_now = on;
    endtask

    task automatic random_item(input int read_pct);
        int         r;
        logic [7:0] head;
        r    = $urandom_range(0, 99);
        head = 8'($urandom_range(0, 255)) | 8'(1 << HDR_SYNC);
        if (r < read_pct)
            push_word(KIND_READ, 8'($urandom_range(0, 255)));
        else if (r < read_pct + 5)
            push_word(KIND_BYTE, 8'($urandom_range(0, 255)));
        else if (r < read_pct + 7)
            push_word(KIND_BYTE, BYTE_ACK);
        else if (r < read_pct + 9) begin
            push_word(KIND_BYTE, BYTE_TEST_OK);
            push_word(KIND_BYTE, 8'h00);
        end
        else
            send_packet(head, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                        8'($urandom_range(0, 255)));
    endtask

    initial
    begin
        int phase_end;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty read, lost sync, lone acknowledge
        set_wheel(1'b0);
        push_word(KIND_READ, 8'hFF);
        push_word(KIND_BYTE, 8'h00);
        push_word(KIND_BYTE, BYTE_ACK);
        // zero movement, both axes overflowed negative, both overflowed positive
        send_packet(8'h08, 8'h00, 8'h00, 8'h00);
        send_packet(8'hFF, 8'hFF, 8'hFF, 8'h00);
        send_packet(8'hCF, 8'h7F, 8'h01, 8'h00);
        // attach flushes the queued records, so the read finds nothing
        push_word(KIND_BYTE, BYTE_TEST_OK);
        push_word(KIND_BYTE, 8'h00);
        push_word(KIND_READ, 8'h00);
        // four-byte packet with a negative wheel delta
        set_wheel(1'b1);
        send_packet(8'h3C, 8'h80, 8'h7F, 8'h80);
        // wheel switched off with three bytes held: fourth byte completes, no wheel
        push_word(KIND_BYTE, 8'h1A);
        push_word(KIND_BYTE, 8'h05);
        push_word(KIND_BYTE, 8'hFB);
        set_wheel(1'b0);
        push_word(KIND_BYTE, 8'h7F);
        // wheel switched on with two bytes held: packet grows to four
        push_word(KIND_BYTE, 8'h29);
        push_word(KIND_BYTE, 8'h01);
        set_wheel(1'b1);
        push_word(KIND_BYTE, 8'h02);
        push_word(KIND_BYTE, 8'h7F);
        repeat (4) push_word(KIND_READ, 8'h55);

        // Random phases, alternating the wheel register
        words_sent = 0;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            set_wheel(ph % 2 == 0);
            gaps_on  = (ph != 2);
            stall_on = (ph != 2);
            phase_end = (ph + 1) * RANDOM_WORDS / PHASES;
            if (ph == 0) begin
                // long receiver hold while the sender keeps offering
                hold_request = 1'b1;
                repeat (40) random_item(read_share[ph]);
                settle();
            end
            while (words_sent < phase_end)
                random_item(read_share[ph]);
        end

        // Drain and give the verdict
        settle();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
